>>> rtl/core/lut_linear_interp_by_current_defines.svh
// Assertion macros shared by the lookup-table interpolator modules.
`ifndef LUT_LINEAR_INTERP_BY_CURRENT_DEFINES_SVH
`define LUT_LINEAR_INTERP_BY_CURRENT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLIC_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLIC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/core/llic_pkg.sv
// Types and constants shared by the lookup-table interpolator modules.
package llic_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int CSR_W = 5;
   localparam int IDX_IN_W = 4;
   localparam int DATA_W = 16;
   localparam int WEIGHT_W = 16;
   localparam int FRAC_W = 14;
   localparam int SPAN_W = DATA_W + 1;
   localparam int ACC_W = WEIGHT_W + SPAN_W + 1;
   localparam int RES_W = ACC_W - FRAC_W + 1;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [IDX_IN_W-1:0]      entry_index;
      logic signed [DATA_W-1:0] q_current;
      logic signed [DATA_W-1:0] d_current;
      logic [DATA_W-1:0]        d_inductance;
      logic [DATA_W-1:0]        q_inductance;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] d_current_ref;
      logic signed [DATA_W-1:0] q_current_out;
      logic [DATA_W-1:0]        d_inductance_out;
      logic [DATA_W-1:0]        q_inductance_out;
      logic [IDX_IN_W-1:0]      segment;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] iq;
      logic signed [DATA_W-1:0] id;
      logic [DATA_W-1:0]        ld;
      logic [DATA_W-1:0]        lq;
   } point_type;

   typedef struct packed {
      logic load;
      logic step;
      logic last;
   } mac_ctrl_type;

endpackage

>>> rtl/core/llic_div.sv
// Bit-serial signed divider that produces the saturated Q2.14 segment weight.
`include "lut_linear_interp_by_current_defines.svh"

module llic_div
   import llic_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SPAN_W-1:0]   num,
   input  logic signed [SPAN_W-1:0]   den,
   output logic                       done,
   output logic signed [WEIGHT_W-1:0] weight
);

   localparam int CNT_W = $clog2(WEIGHT_W);
   localparam int SH = WEIGHT_W - FRAC_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WEIGHT_W - 1);
   localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W - 1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W - 1){1'b0}}};

   logic [DATA_W-1:0]          mag_num;
   logic [DATA_W-1:0]          mag_den;
   logic                       neg;
   logic                       zero_den;
   logic                       ovf;
   logic [DATA_W:0]            trial;
   logic                       ge;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       neg_ff, neg_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [DATA_W-1:0]          dmag_ff, dmag_in;
   logic [DATA_W-1:0]          rem_ff, rem_in;
   logic [WEIGHT_W-1:0]        dvd_ff, dvd_in;
   logic [WEIGHT_W-1:0]        quo_ff, quo_in;
   logic signed [WEIGHT_W-1:0] weight_ff, weight_in;

   assign mag_num = DATA_W'(num[SPAN_W-1] ? -num : num);
   assign mag_den = DATA_W'(den[SPAN_W-1] ? -den : den);
   assign neg = num[SPAN_W-1] ^ den[SPAN_W-1];
   assign zero_den = (den == '0);
   assign ovf = ({{SH{1'b0}}, mag_num} >= {mag_den, {SH{1'b0}}});
   assign trial = {rem_ff, dvd_ff[WEIGHT_W-1]};
   assign ge = (trial >= {1'b0, dmag_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      dmag_in = dmag_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      weight_in = weight_ff;
      if (start) begin
         neg_in = neg;
         dmag_in = mag_den;
         rem_in = mag_num >> SH;
         dvd_in = {mag_num[SH-1:0], {FRAC_W{1'b0}}};
         quo_in = '0;
         cnt_in = '0;
         if (zero_den) begin
            weight_in = '0;
            done_in = 1'b1;
         end else if (ovf) begin
            weight_in = neg ? W_MIN : W_MAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? DATA_W'(trial - {1'b0, dmag_ff}) : DATA_W'(trial);
         dvd_in = dvd_ff << 1;
         quo_in = {quo_ff[WEIGHT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               weight_in = quo_in[WEIGHT_W-1] ? W_MAX : $signed(quo_in);
            end else begin
               weight_in = (quo_in[WEIGHT_W-1] && (|quo_in[WEIGHT_W-2:0])) ? W_MIN :
                           $signed(~quo_in + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      dmag_ff <= dmag_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      weight_ff <= weight_in;
   end

   assign done = done_ff;
   assign weight = weight_ff;

   `LLIC_ASSERT_IMP(a_start_when_idle, start, !busy_ff, "Divider started while busy.")
   `LLIC_ASSERT_NEXT(a_last_step_done, busy_ff && (cnt_ff == CNT_LAST), done_ff && !busy_ff,
      "Divider did not finish after its last step.")
   `LLIC_ASSERT_NEXT(a_shortcut_done, start && (zero_den || ovf), done_ff && !busy_ff,
      "Zero or saturating division did not finish at once.")

endmodule

>>> rtl/core/llic_mac.sv
// Bit-serial multiply-accumulate lane that forms a + round(w * (b - a) / 2^14).
module llic_mac
   import llic_pkg::*;
(
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic                     w_bit,
   input  logic signed [SPAN_W-1:0] a,
   input  logic signed [SPAN_W-1:0] b,
   output logic signed [RES_W-1:0]  y
);

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  mcand_ff, mcand_in;
   logic signed [SPAN_W-1:0] a_ff, a_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      a_in = a_ff;
      if (ctrl.load) begin
         acc_in = ROUND_HALF;
         mcand_in = ACC_W'(b) - ACC_W'(a);
         a_in = a;
      end else if (ctrl.step) begin
         if (w_bit) begin
            acc_in = ctrl.last ? acc_ff - mcand_ff : acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      a_ff <= a_in;
   end

   assign y = RES_W'(a_ff) + RES_W'(acc_ff >>> FRAC_W);

endmodule

>>> rtl/core/lut_linear_interp_by_current.sv
// Top level of the operating-point lookup table with linear interpolation by q current.
//
// Usage: req_* carries one transaction per item. A write transaction (mode 0) stores one
// table entry and leaves the block idle, so the next transaction can follow at once.
// A query transaction (mode 1) scans the active entries one per cycle for the first
// q-current span that holds the reference, divides for the weight one bit per cycle,
// then runs three bit-serial multiply lanes in parallel, one weight bit per cycle.
// A query answers on rsp_* after its scan, the 16-step divider and the 16-step
// multiplier; a zero span or a saturating weight skips the divider's steps, and an
// empty table skips the scan, divide and multiply. The block takes its next transaction
// in the same cycle as the answer appears, and takes none while a query runs.
// The active count is written on csr_*, which is always ready; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// The result waits in an output register, and a new transaction is accepted while it
// waits; when the receiver stalls, a finished query holds until the register is free.
// Reset clears the active count and the held inductances and empties the pipeline;
// the table itself keeps no reset value and must be written before it is queried.
`include "lut_linear_interp_by_current_defines.svh"

module lut_linear_interp_by_current
   import llic_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int N_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int MUL_CNT_W = $clog2(WEIGHT_W);
   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(WEIGHT_W - 1);
   localparam logic signed [RES_W-1:0] I_MAX = RES_W'((1 << (DATA_W - 1)) - 1);
   localparam logic signed [RES_W-1:0] I_MIN = RES_W'(-(1 << (DATA_W - 1)));
   localparam logic signed [RES_W-1:0] L_MAX = RES_W'((1 << DATA_W) - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DIVS   = 3'd2;
   localparam logic [2:0] ST_DIVW   = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   point_type tbl_mem [TABLE_DEPTH];
   point_type rd_data_ff;
   logic      tbl_we;
   logic [IDX_W-1:0] tbl_waddr;
   point_type tbl_wdata;

   logic                     req_accept;
   logic [N_W-1:0]           count_ext;
   logic [N_W-1:0]           depth_ext;
   logic [N_W-1:0]           n_act;
   logic                     in_range;
   logic                     scan_first;
   logic                     scan_end;

   logic                       div_start;
   logic signed [SPAN_W-1:0]   div_num;
   logic signed [SPAN_W-1:0]   div_den;
   logic                       div_done;
   logic signed [WEIGHT_W-1:0] div_weight;

   mac_ctrl_type             mac_ctrl;
   logic signed [RES_W-1:0]  y_id;
   logic signed [RES_W-1:0]  y_ld;
   logic signed [RES_W-1:0]  y_lq;
   logic signed [DATA_W-1:0] id_sat;
   logic [DATA_W-1:0]        ld_sat;
   logic [DATA_W-1:0]        lq_sat;

   logic [2:0]               state_ff, state_in;
   logic [CSR_W-1:0]         entry_count_ff, entry_count_in;
   logic [DATA_W-1:0]        held_ld_ff, held_ld_in;
   logic [DATA_W-1:0]        held_lq_ff, held_lq_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rd_addr_ff, rd_addr_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic signed [DATA_W-1:0] qref_ff, qref_in;
   logic [IDX_W-1:0]         last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]         cur_idx_ff, cur_idx_in;
   logic [IDX_W-1:0]         seg_ff, seg_in;
   point_type                lo_ff, lo_in;
   point_type                hi_ff, hi_in;
   logic                     empty_ff, empty_in;
   logic [WEIGHT_W-1:0]      w_sr_ff, w_sr_in;
   logic [MUL_CNT_W-1:0]     mul_cnt_ff, mul_cnt_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_accept = req_valid && req_ready;

   assign tbl_we = req_accept && (req_data.mode == MODE_WRITE) &&
                   (N_W'(req_data.entry_index) < N_W'(TABLE_DEPTH));
   assign tbl_waddr = IDX_W'(req_data.entry_index);
   assign tbl_wdata = '{iq: req_data.q_current, id: req_data.d_current,
                        ld: req_data.d_inductance, lq: req_data.q_inductance};

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      rd_data_ff <= tbl_mem[rd_addr_ff];
   end

   assign count_ext = N_W'(entry_count_ff);
   assign depth_ext = N_W'(TABLE_DEPTH);
   assign n_act = (count_ext > depth_ext) ? depth_ext : count_ext;
   assign in_range = (qref_ff >= lo_ff.iq) && (qref_ff <= rd_data_ff.iq);
   assign scan_first = (cur_idx_ff == '0);
   assign scan_end = (cur_idx_ff == last_idx_ff) || (!scan_first && in_range);

   assign div_num = SPAN_W'(qref_ff) - SPAN_W'(lo_ff.iq);
   assign div_den = SPAN_W'(hi_ff.iq) - SPAN_W'(lo_ff.iq);

   llic_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .done   (div_done),
      .weight (div_weight)
   );

   llic_mac u_mac_id (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .w_bit (w_sr_ff[0]),
      .a     (SPAN_W'(lo_ff.id)),
      .b     (SPAN_W'(hi_ff.id)),
      .y     (y_id)
   );

   llic_mac u_mac_ld (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .w_bit (w_sr_ff[0]),
      .a     ($signed({1'b0, lo_ff.ld})),
      .b     ($signed({1'b0, hi_ff.ld})),
      .y     (y_ld)
   );

   llic_mac u_mac_lq (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .w_bit (w_sr_ff[0]),
      .a     ($signed({1'b0, lo_ff.lq})),
      .b     ($signed({1'b0, hi_ff.lq})),
      .y     (y_lq)
   );

   assign id_sat = (y_id > I_MAX) ? DATA_W'(I_MAX) :
                   (y_id < I_MIN) ? DATA_W'(I_MIN) : DATA_W'(y_id);
   assign ld_sat = (y_ld < 0) ? '0 : (y_ld > L_MAX) ? DATA_W'(L_MAX) : DATA_W'(y_ld);
   assign lq_sat = (y_lq < 0) ? '0 : (y_lq > L_MAX) ? DATA_W'(L_MAX) : DATA_W'(y_lq);

   always_comb begin
      state_in = state_ff;
      entry_count_in = entry_count_ff;
      held_ld_in = held_ld_ff;
      held_lq_in = held_lq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      rd_addr_in = '0;
      qref_in = qref_ff;
      last_idx_in = last_idx_ff;
      cur_idx_in = cur_idx_ff;
      seg_in = seg_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      empty_in = empty_ff;
      w_sr_in = w_sr_ff;
      mul_cnt_in = mul_cnt_ff;
      div_start = 1'b0;
      mac_ctrl = '0;
      if (csr_valid && csr_ready) begin
         entry_count_in = csr_wdata;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.mode == MODE_QUERY)) begin
               qref_in = req_data.q_current;
               cur_idx_in = '0;
               if (n_act == '0) begin
                  empty_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  empty_in = 1'b0;
                  last_idx_in = IDX_W'(n_act - 1'b1);
                  rd_addr_in = IDX_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               hi_in = rd_data_ff;
               if (scan_first) begin
                  lo_in = rd_data_ff;
                  seg_in = '0;
               end else begin
                  seg_in = cur_idx_ff - 1'b1;
               end
               state_in = ST_DIVS;
            end else begin
               lo_in = rd_data_ff;
               cur_idx_in = cur_idx_ff + 1'b1;
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         ST_DIVS: begin
            div_start = 1'b1;
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               w_sr_in = div_weight;
               mul_cnt_in = '0;
               mac_ctrl.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mac_ctrl.step = 1'b1;
            w_sr_in = w_sr_ff >> 1;
            mul_cnt_in = mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == MUL_LAST) begin
               mac_ctrl.last = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (empty_ff) begin
                  rsp_data_in.d_current_ref = '0;
                  rsp_data_in.q_current_out = '0;
                  rsp_data_in.d_inductance_out = held_ld_ff;
                  rsp_data_in.q_inductance_out = held_lq_ff;
                  rsp_data_in.segment = '0;
               end else begin
                  rsp_data_in.d_current_ref = id_sat;
                  rsp_data_in.q_current_out = qref_ff;
                  rsp_data_in.d_inductance_out = ld_sat;
                  rsp_data_in.q_inductance_out = lq_sat;
                  rsp_data_in.segment = IDX_IN_W'(seg_ff);
                  held_ld_in = ld_sat;
                  held_lq_in = lq_sat;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_count_ff <= '0;
         held_ld_ff <= '0;
         held_lq_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         entry_count_ff <= entry_count_in;
         held_ld_ff <= held_ld_in;
         held_lq_ff <= held_lq_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_addr_ff <= rd_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      qref_ff <= qref_in;
      last_idx_ff <= last_idx_in;
      cur_idx_ff <= cur_idx_in;
      seg_ff <= seg_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      empty_ff <= empty_in;
      w_sr_ff <= w_sr_in;
      mul_cnt_ff <= mul_cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `LLIC_ASSERT_IMP(a_scan_bound, state_ff == ST_SCAN, cur_idx_ff <= last_idx_ff,
      "Scan ran past the last active entry.")
   `LLIC_ASSERT_IMP(a_div_done_in_wait, div_done, state_ff == ST_DIVW,
      "Divider finished outside the wait state.")
   `LLIC_ASSERT_NEXT(a_finish_loads_output,
      (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready),
      rsp_valid_ff && (state_ff == ST_IDLE),
      "Finished query did not reach the output register.")

endmodule
